### rtl/core/mnse_pkg.sv
// -----------------------------------------------------------------------------
// MOSFET Newton step evaluator package
// Shared widths, fixed-point constants, register codes and unit handshake types.
// -----------------------------------------------------------------------------
package mnse_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VW = 32;
	localparam int GW = 33;
	localparam int RW = 26;
	localparam int TW = 20;
	localparam int AW = 4;
	localparam int EW = 36;
	localparam int MW = 64;
	localparam int DDW = 63;
	localparam int DSW = 32;
	localparam int D100_SH = 41 - FRAC_BITS;

	localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
	localparam logic [63:0] HALF_V    = 64'd1 << (FRAC_BITS - 1);
	localparam logic [63:0] TOL_ABS   = ONE / 100;
	localparam logic [63:0] STEP_INC  = (ONE + 64'd5000) / 10000;
	localparam logic [63:0] RON_MAX   = 64'd1000 << FRAC_BITS;
	localparam logic [63:0] TH_MIN    = ONE / 100;
	localparam logic [63:0] TH_MAX    = (64'd999 << FRAC_BITS) / 100;
	localparam logic [63:0] TH_RESET  = 64'd3 << FRAC_BITS;
	localparam logic [63:0] TEN_V     = 64'd10 << FRAC_BITS;
	localparam logic [63:0] PROD_LIM  = (64'd1 << (62 - FRAC_BITS)) - 64'd1;
	localparam logic [63:0] SAT62     = 64'd1 << 62;
	localparam logic [63:0] G_MAX     = 64'h1_FFFF_FFFF;
	localparam logic [63:0] RECIP_NUM = 64'd1 << (2 * FRAC_BITS);
	localparam logic [63:0] SC_RESET  = RECIP_NUM / ONE;
	localparam logic [63:0] RECIP_100 = ((64'd1 << 41) + 64'd99) / 100;

	typedef enum logic [1:0] {
		REG_ON_RES = 2'd0,
		REG_THRESH = 2'd1,
		REG_PCH    = 2'd2,
		REG_DEPL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [RW-1:0] on_resistance;
		logic [TW-1:0] threshold_volt;
		logic          p_channel;
		logic          depletion_mode;
	} cfg_t;

	typedef struct packed {
		logic          start;
		logic [MW-1:0] a;
		logic [MW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic          done;
		logic [MW-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic           start;
		logic [DDW-1:0] dividend;
		logic [DSW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [DDW-1:0] quot;
	} div_rsp_t;

endpackage

### rtl/core/mnse_if.sv
// -----------------------------------------------------------------------------
// MOSFET Newton step evaluator channels
// Valid/ready channels for the voltage items and the stamp result items.
// -----------------------------------------------------------------------------
interface mnse_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drain_volt;
	logic signed [31:0] source_volt;
	logic signed [31:0] gate_volt;
	logic               gate_connected;
	logic               restart;

	modport source (output valid, drain_volt, source_volt, gate_volt, gate_connected, restart,
		input ready);
	modport sink (input valid, drain_volt, source_volt, gate_volt, gate_connected, restart,
		output ready);
endinterface

interface mnse_out_if;
	logic               valid;
	logic               ready;
	logic               converged;
	logic signed [31:0] drain_current;
	logic [32:0]        conductance;
	logic               restamp;

	modport source (output valid, converged, drain_current, conductance, restamp, input ready);
	modport sink (input valid, converged, drain_current, conductance, restamp, output ready);
endinterface

### rtl/core/mnse_cfg.sv
// -----------------------------------------------------------------------------
// MOSFET Newton step evaluator register file
// APB-style register port that clamps resistance and range-checks threshold.
// -----------------------------------------------------------------------------
module mnse_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [mnse_pkg::AW-1:0]  paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output mnse_pkg::cfg_t           cfg
);
	import mnse_pkg::*;

	logic          wr;
	reg_idx_t      idx;
	logic [RW-1:0] ron_w;
	logic [TW-1:0] th_w;
	logic          th_ok;
	cfg_t          cfg_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_comb begin
		ron_w = pwdata[RW-1:0];
		if (ron_w == '0) begin
			ron_w = RW'(1);
		end else if (64'(ron_w) > RON_MAX) begin
			ron_w = RON_MAX[RW-1:0];
		end
		th_w  = pwdata[TW-1:0];
		th_ok = 64'(th_w) >= TH_MIN;
		if (64'(th_w) > TH_MAX) begin
			th_w = TH_MAX[TW-1:0];
		end
	end

	always_comb begin
		case (idx)
			REG_ON_RES: prdata = 32'(cfg_q.on_resistance);
			REG_THRESH: prdata = 32'(cfg_q.threshold_volt);
			REG_PCH:    prdata = 32'(cfg_q.p_channel);
			REG_DEPL:   prdata = 32'(cfg_q.depletion_mode);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_resistance  <= ONE[RW-1:0];
			cfg_q.threshold_volt <= TH_RESET[TW-1:0];
			cfg_q.p_channel      <= 1'b0;
			cfg_q.depletion_mode <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_ON_RES: cfg_q.on_resistance <= ron_w;
				REG_THRESH: begin
					if (th_ok) begin
						cfg_q.threshold_volt <= th_w;
					end
				end
				REG_PCH:    cfg_q.p_channel <= pwdata[0];
				REG_DEPL:   cfg_q.depletion_mode <= pwdata[0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

### rtl/core/mnse_mul.sv
// -----------------------------------------------------------------------------
// MOSFET Newton step evaluator multiplier
// Shared 32x32 multiplier that builds a fixed-point 64x64 magnitude product
// from four partial products and saturates it.
// -----------------------------------------------------------------------------
module mnse_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  mnse_pkg::mul_req_t  req,
	output mnse_pkg::mul_rsp_t  rsp
);
	import mnse_pkg::*;

	logic [MW-1:0]   a_q;
	logic [MW-1:0]   b_q;
	logic [2:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            pv_s1;
	logic [1:0]      sh_s1;
	logic [63:0]     p_s1;
	logic [127:0]    acc_q;
	logic [31:0]     ah;
	logic [31:0]     bh;
	logic [63:0]     pp;

	assign ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	assign pp = ah * bh;

	assign rsp.done = done_q;
	assign rsp.prod = ((acc_q >> (62 + FRAC_BITS)) != '0) ? SAT62 : acc_q[FRAC_BITS +: 64];

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			p_s1  <= pp;
			sh_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			if (pv_s1) begin
				acc_q <= acc_q + ({64'b0, p_s1} << {sh_s1, 5'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
		end else if (busy_q) begin
			pv_s1  <= cnt_q < 3'd4;
			cnt_q  <= cnt_q + 3'd1;
			busy_q <= cnt_q != 3'd4;
			done_q <= cnt_q == 3'd4;
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

### rtl/core/mnse_div.sv
// -----------------------------------------------------------------------------
// MOSFET Newton step evaluator divider
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// -----------------------------------------------------------------------------
module mnse_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mnse_pkg::div_req_t  req,
	output mnse_pkg::div_rsp_t  rsp
);
	import mnse_pkg::*;

	logic [DDW-1:0] dq_q;
	logic [DSW-1:0] dv_q;
	logic [DSW-1:0] rem_q;
	logic [5:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DSW:0]   sh;
	logic [DSW+1:0] trial;
	logic           ge;

	assign sh    = {rem_q, dq_q[DDW-1]};
	assign trial = {1'b0, sh} - {2'b0, dv_q};
	assign ge    = !trial[DSW+1];

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dv_q  <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DSW-1:0] : sh[DSW-1:0];
			dq_q  <= {dq_q[DDW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 6'd1;
			busy_q <= cnt_q != 6'(DDW - 1);
			done_q <= cnt_q == 6'(DDW - 1);
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

### rtl/core/mosfet_newton_step_evaluator_unit.sv
// -----------------------------------------------------------------------------
// MOSFET Newton step evaluator
// Convergence test, swing limiting and square-law drain current of one solver
// iteration, on a shared multiplier and divider under a small sequencer.
// -----------------------------------------------------------------------------
// Each item runs a 63-step divider pass for the reciprocal, a conducting one
// runs a second; the divider passes dominate the work of an item.
// One item is in work at a time; the next is taken once the result is registered,
// even while that result still waits on the output.
// Reset clears the sequencer, the stored voltages and the damping step, restores
// the default registers and sets the stored conductance to 1/on_resistance.
module mosfet_newton_step_evaluator_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [mnse_pkg::AW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	mnse_in_if.sink                 volts,
	mnse_out_if.source              stamp
);
	import mnse_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_RECIP = 12'b0000_0000_0010,
		S_CHK   = 12'b0000_0000_0100,
		S_EVAL  = 12'b0000_0000_1000,
		S_MAXC  = 12'b0000_0001_0000,
		S_D100  = 12'b0000_0010_0000,
		S_M1    = 12'b0000_0100_0000,
		S_M2    = 12'b0000_1000_0000,
		S_M3    = 12'b0001_0000_0000,
		S_M4    = 12'b0010_0000_0000,
		S_DIV   = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	localparam logic signed [EW-1:0] HALF_E = EW'(HALF_V);

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	cfg_t     cfg;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t                state_q;
	logic signed [VW-1:0]  vd_q, vs_q, vg_q;
	logic                  rst_q;
	logic signed [VW-1:0]  prev_d_q, prev_s_q, prev_g_q;
	logic [31:0]           damp_q;
	logic [GW-1:0]         sc_q;
	logic [GW-1:0]         g_q;
	logic [1:0]            idx_q;
	logic                  ok_q;
	logic                  conv_q;
	logic signed [EW-1:0]  vds_q, gv_q, v2_q;
	logic signed [63:0]    maxc_q, satk_q, t1_q, cur_q;
	logic [63:0]           prodm_q;
	logic                  prodn_q;
	logic [GW-1:0]         adm_q;
	logic                  out_valid_q;
	logic                  out_conv_q;
	logic signed [31:0]    out_cur_q;
	logic [GW-1:0]         out_cond_q;
	logic                  out_restamp_q;

	logic                  accept;
	logic                  out_load;
	logic signed [VW-1:0]  ck_pre, ck_post;
	logic signed [VW:0]    ck_diff;
	logic [VW:0]           ck_dmag;
	logic [39:0]           ck_dsc;
	logic [VW:0]           ck_tol;
	logic [VW-1:0]         ck_pmag;
	logic                  ck_close;

	logic signed [EW-1:0]  vdx, vsx, vgx, pdx, psx, ddx, dsx, ld, ls;
	logic signed [EW-1:0]  vgs0, vds0, vgs1, vds1, vgs2, gth, gv, gvc, v2;
	logic [TW-1:0]         gth_u;
	logic [32:0]           damp_inc;

	logic [63:0]           m;
	logic [GW-1:0]         g_new;
	logic signed [63:0]    quot_s, q100, poly, dsv, ds2, cur2;
	logic [63:0]           pm;
	logic [DSW-1:0]        kdiv;
	logic [63:0]           div_num;
	logic signed [31:0]    cur_sat;

	mnse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mnse_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mnse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign volts.ready         = state_q == S_IDLE;
	assign accept              = volts.valid && volts.ready;
	assign out_load            = (state_q == S_DONE) && (!out_valid_q || stamp.ready);
	assign stamp.valid         = out_valid_q;
	assign stamp.converged     = out_conv_q;
	assign stamp.drain_current = out_cur_q;
	assign stamp.conductance   = out_cond_q;
	assign stamp.restamp       = out_restamp_q;

	// Convergence check of one voltage pair per cycle.
	always_comb begin
		case (idx_q)
			2'd0:    begin ck_pre = prev_d_q; ck_post = vd_q; end
			2'd1:    begin ck_pre = prev_s_q; ck_post = vs_q; end
			default: begin ck_pre = prev_g_q; ck_post = vg_q; end
		endcase
		ck_diff  = (VW+1)'(ck_post) - (VW+1)'(ck_pre);
		ck_dmag  = ck_diff[VW] ? (VW+1)'(-ck_diff) : (VW+1)'(ck_diff);
		ck_dsc   = (64'(cfg.on_resistance) < ONE) ? 40'(ck_dmag) * 40'd100 : 40'(ck_dmag);
		ck_tol   = (VW+1)'(TOL_ABS) + (VW+1)'(damp_q);
		ck_pmag  = ck_post[VW-1] ? VW'(-ck_post) : VW'(ck_post);
		ck_close = (ck_dsc < 40'(ck_tol)) || (50'(ck_dsc) * 50'd1000 < 50'(ck_pmag));
	end

	// Swing limit, polarity mirroring and gate overdrive.
	always_comb begin
		vdx   = EW'(vd_q);
		vsx   = EW'(vs_q);
		vgx   = EW'(vg_q);
		pdx   = EW'(prev_d_q);
		psx   = EW'(prev_s_q);
		ddx   = vdx - pdx;
		dsx   = vsx - psx;
		ld    = (ddx > HALF_E) ? pdx + HALF_E : ((ddx < -HALF_E) ? pdx - HALF_E : vdx);
		ls    = (dsx > HALF_E) ? psx + HALF_E : ((dsx < -HALF_E) ? psx - HALF_E : vsx);
		vgs0  = vgx - ls;
		vds0  = ld - ls;
		vgs1  = cfg.p_channel ? -vgs0 : vgs0;
		vds1  = cfg.p_channel ? -vds0 : vds0;
		vgs2  = cfg.depletion_mode ? -vgs1 : vgs1;
		gth_u = cfg.threshold_volt - (cfg.threshold_volt >> 2);
		gth   = $signed(EW'(gth_u));
		gv    = vgs2 - gth;
		gvc   = gv[EW-1] ? '0 : gv;
		v2    = (vds1 > gvc) ? gvc : vds1;
		damp_inc = 33'(damp_q) + 33'(STEP_INC);
	end

	// Shared unit operands and result handling.
	always_comb begin
		m       = mul_rsp.prod;
		g_new   = (64'(div_rsp.quot) > G_MAX) ? G_MAX[GW-1:0] : div_rsp.quot[GW-1:0];
		quot_s  = $signed(64'(div_rsp.quot));
		q100    = $signed(m >> D100_SH);
		poly    = t1_q - $signed(m >> 1);
		pm      = (m > PROD_LIM) ? PROD_LIM : m;
		kdiv    = (m == '0) ? DSW'(1) : m[DSW-1:0];
		div_num = prodm_q << FRAC_BITS;
		dsv     = prodn_q ? -quot_s : quot_s;
		ds2     = (dsv > maxc_q) ? maxc_q : dsv;
		cur2    = cfg.p_channel ? -cur_q : cur_q;
		if (cur2 > 64'sd2147483647) begin
			cur_sat = 32'sh7FFF_FFFF;
		end else if (cur2 < -64'sd2147483648) begin
			cur_sat = 32'sh8000_0000;
		end else begin
			cur_sat = cur2[31:0];
		end

		mul_req = '0;
		div_req = '0;
		case (state_q)
			S_IDLE: begin
				div_req.start    = accept;
				div_req.dividend = RECIP_NUM[DDW-1:0];
				div_req.divisor  = DSW'(cfg.on_resistance);
			end
			S_EVAL: begin
				mul_req.start = !ok_q;
				mul_req.a     = mag64(64'(vds1));
				mul_req.b     = 64'(sc_q);
			end
			S_MAXC: begin
				mul_req.start = mul_rsp.done && (gv_q != '0);
				mul_req.a     = mag64(64'(vds_q));
				mul_req.b     = RECIP_100;
			end
			S_D100: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = mag64(64'(gv_q));
				mul_req.b     = mag64(64'(v2_q));
			end
			S_M1: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = mag64(64'(v2_q));
				mul_req.b     = mag64(64'(v2_q));
			end
			S_M2: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = mag64(poly);
				mul_req.b     = mag64(satk_q);
			end
			S_M3: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = 64'(cfg.on_resistance);
				mul_req.b     = TEN_V - 64'(cfg.threshold_volt);
			end
			S_M4: begin
				div_req.start    = mul_rsp.done;
				div_req.dividend = div_num[DDW-1:0];
				div_req.divisor  = kdiv;
			end
			default: begin
				mul_req = '0;
				div_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					vd_q  <= volts.drain_volt;
					vs_q  <= volts.source_volt;
					vg_q  <= volts.gate_connected ? volts.gate_volt : volts.source_volt;
					rst_q <= volts.restart;
				end
			end
			S_RECIP: begin
				if (div_rsp.done) begin
					g_q <= g_new;
				end
			end
			S_EVAL: begin
				conv_q <= ok_q;
				vds_q  <= vds1;
				gv_q   <= gvc;
				v2_q   <= v2;
				if (ok_q) begin
					cur_q <= '0;
					adm_q <= sc_q;
				end
			end
			S_MAXC: begin
				if (mul_rsp.done) begin
					maxc_q <= vds_q[EW-1] ? -$signed(m) : $signed(m);
					if (gv_q == '0) begin
						cur_q <= '0;
						adm_q <= cfg.depletion_mode ? g_q : '0;
					end
				end
			end
			S_D100: begin
				if (mul_rsp.done) begin
					satk_q <= $signed(ONE) + (vds_q[EW-1] ? -q100 : q100);
				end
			end
			S_M1: begin
				if (mul_rsp.done) begin
					t1_q <= v2_q[EW-1] ? -$signed(m) : $signed(m);
				end
			end
			S_M2: begin
				if (mul_rsp.done) begin
					prodn_q <= poly[63] ^ satk_q[63];
				end
			end
			S_M3: begin
				if (mul_rsp.done) begin
					prodm_q <= pm;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					cur_q <= cfg.depletion_mode ? ds2 : maxc_q - ds2;
					adm_q <= cfg.depletion_mode ? '0 : g_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_d_q    <= '0;
			prev_s_q    <= '0;
			prev_g_q    <= '0;
			damp_q      <= '0;
			sc_q        <= SC_RESET[GW-1:0];
			idx_q       <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (stamp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RECIP;
					end
				end
				S_RECIP: begin
					if (div_rsp.done) begin
						if (rst_q) begin
							prev_d_q <= '0;
							prev_s_q <= '0;
							prev_g_q <= '0;
							damp_q   <= '0;
							sc_q     <= g_new;
						end
						idx_q   <= '0;
						ok_q    <= 1'b1;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					ok_q  <= ok_q && ck_close;
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (ok_q) begin
						damp_q  <= '0;
						state_q <= S_DONE;
					end else begin
						damp_q   <= damp_inc[32] ? 32'hFFFF_FFFF : damp_inc[31:0];
						prev_d_q <= vd_q;
						prev_s_q <= vs_q;
						prev_g_q <= vg_q;
						state_q  <= S_MAXC;
					end
				end
				S_MAXC: begin
					if (mul_rsp.done) begin
						state_q <= (gv_q == '0) ? S_DONE : S_D100;
					end
				end
				S_D100: begin
					if (mul_rsp.done) begin
						state_q <= S_M1;
					end
				end
				S_M1: begin
					if (mul_rsp.done) begin
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (mul_rsp.done) begin
						state_q <= S_M3;
					end
				end
				S_M3: begin
					if (mul_rsp.done) begin
						state_q <= S_M4;
					end
				end
				S_M4: begin
					if (mul_rsp.done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						sc_q    <= adm_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_conv_q    <= conv_q;
			out_cur_q     <= cur_sat;
			out_cond_q    <= adm_q;
			out_restamp_q <= adm_q != sc_q;
		end
	end

	a_one_unit_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("multiplier and divider started together");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !volts.ready)
		else $error("block ready again right after taking an item");

	a_converged_clean: assert property (@(posedge clk) disable iff (!arst_n)
		stamp.valid && stamp.converged |-> !stamp.restamp && stamp.drain_current == 32'sd0)
		else $error("converged result carries current or restamp");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_RECIP || state_q == S_DIV))
		else $error("divider finished outside a divide step");

endmodule
